// ===== hdl/bsr_pkg.sv =====
`timescale 1ns / 1ps

package bsr_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int MODE_W    = 3;
  localparam int FILL_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_REMOVE = 3'd4
  } op_t;

  typedef struct packed {
    logic                     push;
    logic                     remove;
    logic signed [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

// ===== hdl/bsr_req_if.sv =====
`timescale 1ns / 1ps

interface bsr_req_if import bsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic signed [WORD_W-1:0] value;

  modport source (output valid, mode, value, input ready);
  modport sink   (input valid, mode, value, output ready);
endinterface

// ===== hdl/bsr_rsp_if.sv =====
`timescale 1ns / 1ps

interface bsr_rsp_if import bsr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] read_value;
  logic [FILL_W-1:0]        fill_count;
  logic                     is_empty;
  logic                     is_full;

  modport source (output valid, ok, read_value, fill_count, is_empty, is_full, input ready);
  modport sink   (input valid, ok, read_value, fill_count, is_empty, is_full, output ready);
endinterface

// ===== hdl/bsr_cell.sv =====
`timescale 1ns / 1ps

module bsr_cell import bsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF,
  parameter int INDEX = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic [CW-1:0]            count,
  input  logic signed [WORD_W-1:0] above_data,
  input  logic                     above_match_in,
  input  logic                     sel_in,
  input  logic signed [WORD_W-1:0] rd_in,
  output logic signed [WORD_W-1:0] data,
  output logic                     above_match_out,
  output logic                     sel_out,
  output logic signed [WORD_W-1:0] rd_out
);

  logic live;
  logic match;
  logic wr;

  assign live            = CW'(INDEX) < count;
  assign match           = ctl.remove && live && (data == ctl.value);
  assign above_match_out = above_match_in | match;
  assign sel_out         = sel_in | (match & ~above_match_in);
  assign wr              = ctl.push && (CW'(INDEX) == count);
  assign rd_out          = (CW'(INDEX + 1) == count) ? data : rd_in;

  always_ff @(posedge clk) begin
    if (wr) begin
      data <= ctl.value;
    end else if (sel_out) begin
      data <= above_data;
    end
  end

endmodule

// ===== hdl/bounded_stack_with_remove_top.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Fields
// req       in   mode, value
// rsp       out  ok, read_value, fill_count, is_empty, is_full
//
// One word is accepted per cycle; its result appears in the output register
// on the next cycle. Remove searches and shifts the row of cells in that cycle.
// req is held off only while a result waits in the output register and rsp is
// not ready.
// rst clears the fill count and the output valid; cell contents are not reset.

module bounded_stack_with_remove_top import bsr_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  bsr_req_if.sink   req,
  bsr_rsp_if.source rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                     acc;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;
  logic                     ok_c;
  logic                     rd_op;
  logic                     found;
  cell_ctl_t                ctl;

  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic signed [WORD_W-1:0] rd_chain  [DEPTH+1];
  logic                     above_ch  [DEPTH+1];
  logic                     sel_ch    [DEPTH+1];

  assign req.ready = ~rsp.valid | rsp.ready;
  assign acc       = req.valid & req.ready;

  assign ctl.push   = acc && (req.mode == OP_PUSH);
  assign ctl.remove = acc && (req.mode == OP_REMOVE);
  assign ctl.value  = req.value;

  assign rd_chain[DEPTH] = '0;
  assign above_ch[DEPTH] = 1'b0;
  assign sel_ch[0]       = 1'b0;
  assign found           = above_ch[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] above_data;
    if (i == DEPTH - 1) begin : g_top
      assign above_data = '0;
    end else begin : g_mid
      assign above_data = cell_data[i+1];
    end
    bsr_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
      .clk             (clk),
      .ctl             (ctl),
      .count           (count),
      .above_data      (above_data),
      .above_match_in  (above_ch[i+1]),
      .sel_in          (sel_ch[i]),
      .rd_in           (rd_chain[i+1]),
      .data            (cell_data[i]),
      .above_match_out (above_ch[i]),
      .sel_out         (sel_ch[i+1]),
      .rd_out          (rd_chain[i])
    );
  end

  always_comb begin
    ok_c       = 1'b0;
    rd_op      = 1'b0;
    count_next = count;
    case (op_t'(req.mode))
      OP_PUSH: begin
        ok_c = count < CW'(DEPTH);
        if (ok_c) count_next = count + CW'(1);
      end
      OP_POP: begin
        ok_c  = count != '0;
        rd_op = 1'b1;
        if (ok_c) count_next = count - CW'(1);
      end
      OP_PEEK: begin
        ok_c  = count != '0;
        rd_op = 1'b1;
      end
      OP_CLEAR: begin
        ok_c = count != '0;
        count_next = '0;
      end
      OP_REMOVE: begin
        ok_c = found;
        if (ok_c) count_next = count - CW'(1);
      end
      default: begin
        ok_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (acc) begin
        count <= count_next;
      end
      if (acc) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rsp.ok         <= ok_c;
      rsp.read_value <= (ok_c && rd_op) ? rd_chain[0] : '0;
      rsp.fill_count <= FILL_W'(count_next);
      rsp.is_empty   <= count_next == '0;
      rsp.is_full    <= count_next == CW'(DEPTH);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.push && (count < CW'(DEPTH)) |=> count == $past(count) + CW'(1))
    else $error("push did not advance fill count");

  a_remove_live: assert property (@(posedge clk) disable iff (rst)
    ctl.remove && found |-> count != '0)
    else $error("remove matched on empty stack");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    acc |=> rsp.valid)
    else $error("accepted word produced no result");

endmodule
